FILE: sv/rarst_pkg.sv
// Package with the shared constants and types of the range add / range sum block.
package rarst_pkg;

	localparam int MAX_LENGTH = 1024;
	localparam int IDX_W      = 11;
	localparam int ADDR_W     = 10;
	localparam int SUM_W      = 64;
	localparam int VAL_W      = 32;

	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic                   rd_en;
		logic [ADDR_W-1:0]      rd_addr;
		logic                   wr_en;
		logic [ADDR_W-1:0]      wr_addr;
		logic [2*SUM_W-1:0]     wr_data;
	} mem_req_t;

endpackage

FILE: sv/rarst_if.sv
// Valid/ready channel interfaces for requests and query responses.
interface rarst_req_if import rarst_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    command;
	logic [IDX_W-1:0]        range_low;
	logic [IDX_W-1:0]        range_high;
	logic signed [VAL_W-1:0] add_value;

	modport source (output valid, command, range_low, range_high, add_value, input ready);
	modport sink (input valid, command, range_low, range_high, add_value, output ready);
endinterface

interface rarst_rsp_if import rarst_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [SUM_W-1:0] range_sum;

	modport source (output valid, range_sum, input ready);
	modport sink (input valid, range_sum, output ready);
endinterface

FILE: sv/rarst_store.sv
// Node memory holding the two Fenwick accumulators per position, with a registered read.
module rarst_store import rarst_pkg::*; (
	input  logic               clk,
	input  mem_req_t           req,
	output logic [2*SUM_W-1:0] rd_data
);

	logic [2*SUM_W-1:0] mem [MAX_LENGTH];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule

FILE: sv/range_add_range_sum_tree_top.sv
// Top level of the range add / range sum block with its sequencer.
// Usage:
// The req channel carries one transaction per operation: command selects a range add
// or a range sum query over positions range_low to range_high (1-based, clipped to the
// configured length). Only queries produce a transaction on the rsp channel.
// The state is two Fenwick accumulators per position kept in one memory; every step
// of the walk is a read followed by a write or an accumulate.
// A range add walks up to 11 steps from range_low and up to 10 from range_high + 1,
// and no new transaction is accepted until it is done. A range sum query walks up to
// 10 steps for each of the two prefixes.
// A query over an empty or inverted range returns zero.
// Writing cfg_wdata with cfg_we sets the array length; stored values are kept.
// After reset the block runs a clearing pass over all 1024 memory entries with
// req.ready low; the length returns to 1024.
// A query result sits in an output register; the next transaction is accepted while
// it waits. If the receiver stalls, a later query holds at its end until the result
// register is free.
module range_add_range_sum_tree_top import rarst_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_wdata,
	rarst_req_if.sink        req,
	rarst_rsp_if.source      rsp
);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_PREP, S_UPD_RD, S_UPD_WR,
		S_QRY_RD, S_QRY_ACC, S_MUL, S_SUB, S_DONE
	} state_t;

	state_t             state_q;
	logic [ADDR_W-1:0]  clr_q;
	logic [IDX_W-1:0]   len_q;
	logic               cmd_q;
	logic               empty_q;
	logic               second_q;
	logic [IDX_W-1:0]   a_q;
	logic [IDX_W-1:0]   b_q;
	logic [VAL_W-1:0]   v_q;
	logic [IDX_W-1:0]   idx_q;
	logic [SUM_W-1:0]   d1_q;
	logic [SUM_W-1:0]   d2_q;
	logic [SUM_W-1:0]   s1_q;
	logic [SUM_W-1:0]   s2_q;
	logic [SUM_W-1:0]   prod_q;
	logic [SUM_W-1:0]   sum_q;
	logic               rsp_valid_q;
	logic [SUM_W-1:0]   rsp_data_q;

	mem_req_t           mreq;
	logic [2*SUM_W-1:0] rd_data;
	logic [SUM_W-1:0]   rd1;
	logic [SUM_W-1:0]   rd2;
	logic [IDX_W-1:0]   len_eff;
	logic [IDX_W-1:0]   a_c;
	logic [IDX_W-1:0]   b_c;
	logic               empty_c;
	logic [IDX_W-1:0]   low_bit;
	logic [IDX_W:0]     idx_up;
	logic [IDX_W-1:0]   idx_dn;
	logic [SUM_W-1:0]   v_ext;
	logic [IDX_W-1:0]   b_nxt;
	logic [IDX_W-1:0]   mul_x;
	logic               rsp_free;

	function automatic logic [SUM_W-1:0] mul64(input logic [SUM_W-1:0] x,
	                                           input logic [IDX_W-1:0] y);
		mul64 = x * {{(SUM_W-IDX_W){1'b0}}, y};
	endfunction

	rarst_store u_store (
		.clk     (clk),
		.req     (mreq),
		.rd_data (rd_data)
	);

	assign rd1      = rd_data[2*SUM_W-1:SUM_W];
	assign rd2      = rd_data[SUM_W-1:0];
	assign len_eff  = (len_q > IDX_W'(MAX_LENGTH)) ? IDX_W'(MAX_LENGTH) : len_q;
	assign a_c      = (req.range_low == '0) ? IDX_W'(1) : req.range_low;
	assign b_c      = (req.range_high > len_eff) ? len_eff : req.range_high;
	assign empty_c  = (len_eff == '0) || (a_c > b_c);
	assign low_bit  = idx_q & (~idx_q + IDX_W'(1));
	assign idx_up   = {1'b0, idx_q} + {1'b0, low_bit};
	assign idx_dn   = idx_q - low_bit;
	assign v_ext    = {{(SUM_W-VAL_W){v_q[VAL_W-1]}}, v_q};
	assign b_nxt    = b_q + IDX_W'(1);
	assign mul_x    = second_q ? (a_q - IDX_W'(1)) : b_q;
	assign rsp_free = !rsp_valid_q || rsp.ready;

	assign req.ready     = (state_q == S_IDLE);
	assign rsp.valid     = rsp_valid_q;
	assign rsp.range_sum = rsp_data_q;

	always_comb begin
		mreq         = '0;
		mreq.rd_addr = ADDR_W'(idx_q - IDX_W'(1));
		mreq.wr_addr = ADDR_W'(idx_q - IDX_W'(1));
		mreq.wr_data = {rd1 + d1_q, rd2 + d2_q};
		unique case (state_q)
			S_CLEAR: begin
				mreq.wr_en   = 1'b1;
				mreq.wr_addr = clr_q;
				mreq.wr_data = '0;
			end
			S_UPD_RD, S_QRY_RD: mreq.rd_en = 1'b1;
			S_UPD_WR: mreq.wr_en = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			len_q       <= IDX_W'(MAX_LENGTH);
			rsp_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				len_q <= cfg_wdata;
			end
			if (rsp_valid_q && rsp.ready && (state_q != S_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						cmd_q   <= req.command;
						a_q     <= a_c;
						b_q     <= b_c;
						v_q     <= req.add_value;
						empty_q <= empty_c;
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					second_q <= 1'b0;
					s1_q     <= '0;
					s2_q     <= '0;
					sum_q    <= '0;
					if (empty_q) begin
						state_q <= (cmd_q == CMD_ADD) ? S_IDLE : S_DONE;
					end else if (cmd_q == CMD_ADD) begin
						idx_q   <= a_q;
						d1_q    <= v_ext;
						d2_q    <= mul64(v_ext, a_q - IDX_W'(1));
						state_q <= S_UPD_RD;
					end else begin
						idx_q   <= b_q;
						state_q <= S_QRY_RD;
					end
				end
				S_UPD_RD: state_q <= S_UPD_WR;
				S_UPD_WR: begin
					if (idx_up > (IDX_W+1)'(MAX_LENGTH)) begin
						if (!second_q && (b_nxt <= IDX_W'(MAX_LENGTH))) begin
							second_q <= 1'b1;
							idx_q    <= b_nxt;
							d1_q     <= -v_ext;
							d2_q     <= -mul64(v_ext, b_q);
							state_q  <= S_UPD_RD;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						idx_q   <= idx_up[IDX_W-1:0];
						state_q <= S_UPD_RD;
					end
				end
				S_QRY_RD: state_q <= S_QRY_ACC;
				S_QRY_ACC: begin
					s1_q <= s1_q + rd1;
					s2_q <= s2_q + rd2;
					if (idx_dn == '0) begin
						state_q <= S_MUL;
					end else begin
						idx_q   <= idx_dn;
						state_q <= S_QRY_RD;
					end
				end
				S_MUL: begin
					prod_q  <= mul64(s1_q, mul_x);
					state_q <= S_SUB;
				end
				S_SUB: begin
					if (!second_q) begin
						sum_q    <= prod_q - s2_q;
						second_q <= 1'b1;
						s1_q     <= '0;
						s2_q     <= '0;
						idx_q    <= a_q - IDX_W'(1);
						state_q  <= (a_q > IDX_W'(1)) ? S_QRY_RD : S_DONE;
					end else begin
						sum_q   <= sum_q - (prod_q - s2_q);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (rsp_free) begin
						rsp_valid_q <= 1'b1;
						rsp_data_q  <= sum_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: sv/rarst_chk.sv
// Port-level checker for the range add / range sum block and its bind statement.
module rarst_chk import rarst_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input logic             req_command,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input logic [SUM_W-1:0] rsp_sum
);

	logic req_acc;
	assign req_acc = req_valid && req_ready;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sum))
		else $error("Response changed while stalled.");

	a_busy_after_acc: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> !req_ready)
		else $error("Request accepted on two consecutive cycles.");

	a_add_no_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && (req_command == CMD_ADD) |=> !$rose(rsp_valid))
		else $error("Range add produced a response.");

	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !rsp_valid && !req_ready)
		else $error("Activity right after reset.");

endmodule

bind range_add_range_sum_tree_top rarst_chk u_rarst_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.req_command (req.command),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_sum     (rsp.range_sum)
);
